### design/fbpa_pkg.sv
package fbpa_pkg;

   localparam int MAX_BLOCKS = 256;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CNT_W-1:0] HEAD_EMPTY  = CNT_W'(MAX_BLOCKS);
   localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_BLOCKS);

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   localparam logic [ADDR_W-1:0] RST_POOL_BASE   = '0;
   localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE  = SIZE_W'(4);
   localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT = CNT_W'(256);

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

   // write side of the link memory
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [CNT_W-1:0] data;
   } link_wr_type;

endpackage

### design/fixed_block_pool_allocator.sv
// Response: an accepted request sets state_ff to ST_FINISH, and rsp_valid_ff is registered
// from ST_FINISH; the response is strobed on rsp_valid once both registers have been passed.
// A new request is not taken until the last is through: busy is high in ST_FINISH, where a
// get from the free list loads the next head read from the link memory before the next pop.
// Reset: synchronous, pool_base 0, block_size 4, block_count 256, all blocks free.
// The receiver cannot stall: each response is shown for exactly one cycle.
module fixed_block_pool_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic [fbpa_pkg::IDX_W-1:0]        req_block_index,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [fbpa_pkg::IDX_W-1:0]        rsp_granted_index,
   output logic [fbpa_pkg::ADDR_W-1:0]       rsp_granted_address,
   output logic [fbpa_pkg::CNT_W-1:0]        rsp_free_count,
   input  logic                              csr_wr_en,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]       csr_wdata
);
   import fbpa_pkg::*;

   state_type        state_ff, state_in;

   logic [ADDR_W-1:0] pool_base_ff;
   logic [SIZE_W-1:0] block_size_ff;
   logic [CNT_W-1:0]  block_count_ff;

   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  fresh_ff, fresh_in;
   logic [CNT_W-1:0]  free_ff, free_in;

   logic              pop_ff;
   logic              grant_ff;
   status_type        status_ff, status_in;
   logic [IDX_W-1:0]  blk_ff, blk_in;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [CNT_W-1:0]  rsp_free_ff;

   logic              accept;
   logic              csr_hit;
   logic [CNT_W-1:0]  live_count;
   logic [CNT_W-1:0]  new_count;
   logic [CNT_W-1:0]  new_live;
   logic              list_valid;
   logic              get_ok, put_ok, pop_list;
   link_wr_type       link_wr;
   logic [CNT_W-1:0]  link_rd_data;
   logic [ADDR_W-1:0] blk_addr;

   assign accept     = start && !busy;
   assign csr_hit    = csr_wr_en && (csr_index == CSR_POOL_BASE ||
                                     csr_index == CSR_BLOCK_SIZE ||
                                     csr_index == CSR_BLOCK_COUNT);
   assign live_count = (block_count_ff > COUNT_LIMIT) ? COUNT_LIMIT : block_count_ff;
   // pool size in effect after a register write
   assign new_count  = (csr_index == CSR_BLOCK_COUNT) ? csr_wdata[CNT_W-1:0] : block_count_ff;
   assign new_live   = (new_count > COUNT_LIMIT) ? COUNT_LIMIT : new_count;
   assign list_valid = head_ff < HEAD_EMPTY;

   assign get_ok   = accept && req_func == FUNC_GET && free_ff != '0;
   assign put_ok   = accept && req_func == FUNC_PUT && free_ff < live_count;
   assign pop_list = get_ok && list_valid;

   assign link_wr.en   = put_ok;
   assign link_wr.addr = req_block_index;
   assign link_wr.data = head_ff;

   fbpa_link_mem u_link_mem (
      .clock   (clock),
      .wr      (link_wr),
      .rd_en   (pop_list),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (link_rd_data)
   );

   fbpa_addr_gen u_addr_gen (
      .clock (clock),
      .en    (get_ok),
      .blk   (blk_in),
      .size  (block_size_ff),
      .base  (pool_base_ff),
      .addr  (blk_addr)
   );

   // next state
   always_comb begin
      unique case (state_ff)
         ST_IDLE:   state_in = accept ? ST_FINISH : ST_IDLE;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      unique case (state_ff)
         ST_IDLE:   busy = 1'b0;
         ST_FINISH: busy = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

   always_comb begin
      blk_in = pop_list ? head_ff[IDX_W-1:0] : fresh_ff[IDX_W-1:0];

      if (accept && req_func == FUNC_GET && !get_ok) begin
         status_in = STAT_EMPTY;
      end else if (accept && req_func == FUNC_PUT && !put_ok) begin
         status_in = STAT_FULL;
      end else begin
         status_in = STAT_OK;
      end

      head_in  = head_ff;
      fresh_in = fresh_ff;
      free_in  = free_ff;
      priority if (csr_hit) begin
         head_in  = HEAD_EMPTY;
         fresh_in = '0;
         free_in  = new_live;
      end else if (get_ok) begin
         if (!list_valid) begin
            fresh_in = fresh_ff + 1'b1;
         end
         free_in = free_ff - 1'b1;
      end else if (put_ok) begin
         head_in = CNT_W'(req_block_index);
         free_in = free_ff + 1'b1;
      end else if (state_ff == ST_FINISH && pop_ff) begin
         // next head arrives from the link memory in the cycle after the pop
         head_in = link_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pool_base_ff   <= RST_POOL_BASE;
         block_size_ff  <= RST_BLOCK_SIZE;
         block_count_ff <= RST_BLOCK_COUNT;
         head_ff        <= HEAD_EMPTY;
         fresh_ff       <= '0;
         free_ff        <= RST_BLOCK_COUNT;
         pop_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         free_ff      <= free_in;
         rsp_valid_ff <= state_ff == ST_FINISH;
         if (accept) begin
            pop_ff <= pop_list;
         end else if (state_ff == ST_FINISH) begin
            pop_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_POOL_BASE:   pool_base_ff   <= csr_wdata;
               CSR_BLOCK_SIZE:  block_size_ff  <= csr_wdata[SIZE_W-1:0];
               CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // request-side payload
   always_ff @(posedge clock) begin
      if (accept) begin
         grant_ff  <= get_ok;
         status_ff <= status_in;
         blk_ff    <= blk_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH) begin
         rsp_status_ff <= status_ff;
         rsp_index_ff  <= grant_ff ? blk_ff : '0;
         rsp_addr_ff   <= grant_ff ? blk_addr : '0;
         rsp_free_ff   <= free_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_index   = rsp_index_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_free_count      = rsp_free_ff;

   a_rsp_after_finish : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_FINISH))
      else $error("response without a finishing request");

   a_two_cycle : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("request did not complete in two cycles");

   a_free_bound : assert property (@(posedge clock) disable iff (reset)
      free_ff <= live_count)
      else $error("free count above pool size");

   a_fail_no_grant : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STAT_OK |->
         rsp_index_ff == '0 && rsp_addr_ff == '0)
      else $error("failed request carries a grant");

endmodule

### design/fbpa_link_mem.sv
module fbpa_link_mem (
   input  logic                          clock,
   input  fbpa_pkg::link_wr_type         wr,
   input  logic                          rd_en,
   input  logic [fbpa_pkg::IDX_W-1:0]    rd_addr,
   output logic [fbpa_pkg::CNT_W-1:0]    rd_data
);
   import fbpa_pkg::*;

   logic [CNT_W-1:0] mem [MAX_BLOCKS];
   logic [CNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fbpa_addr_gen.sv
module fbpa_addr_gen (
   input  logic                          clock,
   input  logic                          en,
   input  logic [fbpa_pkg::IDX_W-1:0]    blk,
   input  logic [fbpa_pkg::SIZE_W-1:0]   size,
   input  logic [fbpa_pkg::ADDR_W-1:0]   base,
   output logic [fbpa_pkg::ADDR_W-1:0]   addr
);
   import fbpa_pkg::*;

   localparam int PROD_W = IDX_W + SIZE_W;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(blk) * PROD_W'(size);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   // address wraps at the bus width
   assign addr = base + ADDR_W'(prod_ff);

endmodule
